[hdl/ltc_pkg.sv]
// ---------------------------------------------------------------------------
// ltc_pkg
// Shared types and codes for the link-training controller.
// ---------------------------------------------------------------------------
package ltc_pkg;

  // Event codes
  localparam logic [4:0] MODE_TICK       = 5'd0;
  localparam logic [4:0] MODE_TRAIN      = 5'd1;
  localparam logic [4:0] MODE_LINK_SET   = 5'd2;
  localparam logic [4:0] MODE_RATE_SET   = 5'd3;
  localparam logic [4:0] MODE_RATE_SW    = 5'd4;
  localparam logic [4:0] MODE_L0S        = 5'd5;
  localparam logic [4:0] MODE_L1         = 5'd6;
  localparam logic [4:0] MODE_L2         = 5'd7;
  localparam logic [4:0] MODE_LP_EXIT    = 5'd8;
  localparam logic [4:0] MODE_DISABLE    = 5'd9;
  localparam logic [4:0] MODE_LOOPBACK   = 5'd10;
  localparam logic [4:0] MODE_HOTRESET   = 5'd11;
  localparam logic [4:0] MODE_EQ_START   = 5'd12;
  localparam logic [4:0] MODE_PRESET     = 5'd13;
  localparam logic [4:0] MODE_TS1        = 5'd14;
  localparam logic [4:0] MODE_TS2        = 5'd15;
  localparam logic [4:0] MODE_EQ_STEP    = 5'd16;
  localparam logic [4:0] MODE_TRAIN_STEP = 5'd17;
  localparam logic [4:0] MODE_PRSNT      = 5'd18;
  localparam logic [4:0] MODE_MRL        = 5'd19;
  localparam logic [4:0] MODE_PWRGOOD    = 5'd20;
  localparam logic [4:0] MODE_REFCLK     = 5'd21;
  localparam logic [4:0] MODE_PERST      = 5'd22;

  // LTSSM states
  localparam logic [3:0] ST_DETECT   = 4'd0;
  localparam logic [3:0] ST_POLLING  = 4'd1;
  localparam logic [3:0] ST_CONFIG   = 4'd2;
  localparam logic [3:0] ST_L0       = 4'd3;
  localparam logic [3:0] ST_RECOVERY = 4'd4;
  localparam logic [3:0] ST_L0S      = 4'd5;
  localparam logic [3:0] ST_L1       = 4'd6;
  localparam logic [3:0] ST_L2       = 4'd7;
  localparam logic [3:0] ST_DISABLED = 4'd8;
  localparam logic [3:0] ST_LOOPBACK = 4'd9;
  localparam logic [3:0] ST_HOTRESET = 4'd10;

  // Equalization phases
  localparam logic [2:0] EQ_IDLE = 3'd0;
  localparam logic [2:0] EQ_TS1  = 3'd1;
  localparam logic [2:0] EQ_TS2  = 3'd2;
  localparam logic [2:0] EQ_PH2  = 3'd3;
  localparam logic [2:0] EQ_PH3  = 3'd4;
  localparam logic [2:0] EQ_DONE = 3'd5;

  localparam logic [2:0] RATE_MAX   = 3'd4;
  localparam logic [2:0] PRESET_MAX = 3'd7;

  // Slot signal bits
  localparam int unsigned SLOT_PRESENT = 0;
  localparam logic [3:0]  SLOT_ALL     = 4'hF;

  // Pulse codes
  localparam logic [1:0] CLEANUP_NONE = 2'd0;
  localparam logic [1:0] CLEANUP_LINK = 2'd1;
  localparam logic [1:0] CLEANUP_MUX  = 2'd2;
  localparam logic [1:0] SWEV_NONE    = 2'd0;
  localparam logic [1:0] SWEV_START   = 2'd1;
  localparam logic [1:0] SWEV_DONE    = 2'd2;

  // Register map
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam logic        REG_LINK_LAYER  = 1'b0;
  localparam logic        REG_CLEANUP_MUX = 1'b1;

  // Stream widths
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned S_TUSER_W = 5;
  localparam int unsigned M_TDATA_W = 56;

  typedef struct packed {
    logic has_link_layer;
    logic has_cleanup_mux;
  } ltc_cfg_t;

  typedef struct packed {
    logic [4:0] mode;
    logic [2:0] value;
    logic       switch_ready;
  } ltc_item_t;

  typedef struct packed {
    logic [3:0]  link_state;
    logic        link_is_up;
    logic [2:0]  eq_phase_out;
    logic [2:0]  preset_out;
    logic [2:0]  rate_out;
    logic        training_active;
    logic        eq_active;
    logic [15:0] removal_count_out;
    logic [15:0] insertion_count_out;
    logic [1:0]  cleanup_request;
    logic [1:0]  rate_switch_event;
    logic        step_reached;
  } ltc_result_t;

endpackage

[hdl/pcie_link_training_controller.sv]
// ---------------------------------------------------------------------------
// pcie_link_training_controller
// Simplified LTSSM: one event in, one status item out.
// ---------------------------------------------------------------------------
// Usage:
//   Events enter on the s_ stream (event code in s_tuser, argument and
//   switch-ready flag in s_tdata). Each event yields exactly one status item
//   on the m_ stream with link state, equalization phase, preset, rate,
//   flags, removal/insertion counters and the cleanup / rate-switch / step
//   pulses for that event.
//   An accepted event sits in the input register while the event logic
//   updates the state and loads the output register, which drives m_tvalid.
//   Throughput is one event per clock while m_tready stays high.
//   If m_tready is low the output register holds its item; the input register
//   still takes one more event, then s_tready drops until the output drains.
//   Reset (rst, synchronous) empties both registers and returns the link to
//   Detect, Gen1, equalization idle, slot signals cleared and counters zero;
//   config returns to link layer present, no cleanup mux.
//   Config is written over APB (reg 0 at 0x0, reg 1 at 0x4) while idle.
// ---------------------------------------------------------------------------
module pcie_link_training_controller (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ltc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ltc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ltc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  // Event input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ltc_pkg::S_TDATA_W-1:0]   s_tdata,  // value[2:0], switch_ready[3], zero [7:4]
  input  logic [ltc_pkg::S_TUSER_W-1:0]   s_tuser,  // mode[4:0]
  // Status output
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // link_state[3:0], link_is_up[4], eq_phase_out[7:5], preset_out[10:8],
  // rate_out[13:11], training_active[14], eq_active[15],
  // removal_count_out[31:16], insertion_count_out[47:32],
  // cleanup_request[49:48], rate_switch_event[51:50], step_reached[52], zero [55:53]
  output logic [ltc_pkg::M_TDATA_W-1:0]   m_tdata
);
  import ltc_pkg::*;

  ltc_cfg_t    cfg;
  ltc_item_t   in_item;
  logic        in_valid;
  logic        fire;
  ltc_result_t result;
  ltc_result_t out_result;
  logic        out_valid;

  ltc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake control
  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.mode         <= s_tuser;
      in_item.value        <= s_tdata[2:0];
      in_item.switch_ready <= s_tdata[3];
    end
  end

  ltc_event_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (in_item),
    .fire   (fire),
    .result (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0,
                     out_result.step_reached,
                     out_result.rate_switch_event,
                     out_result.cleanup_request,
                     out_result.insertion_count_out,
                     out_result.removal_count_out,
                     out_result.eq_active,
                     out_result.training_active,
                     out_result.rate_out,
                     out_result.preset_out,
                     out_result.eq_phase_out,
                     out_result.link_is_up,
                     out_result.link_state};

endmodule

[hdl/ltc_apb_regs.sv]
// ---------------------------------------------------------------------------
// ltc_apb_regs
// APB configuration registers: link-layer present and cleanup-mux present.
// ---------------------------------------------------------------------------
module ltc_apb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ltc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ltc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ltc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output ltc_pkg::ltc_cfg_t                cfg
);
  import ltc_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.has_link_layer  <= 1'b1;
      cfg.has_cleanup_mux <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_LINK_LAYER:  cfg.has_link_layer  <= pwdata[0];
        REG_CLEANUP_MUX: cfg.has_cleanup_mux <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_LINK_LAYER:  prdata[0] = cfg.has_link_layer;
      REG_CLEANUP_MUX: prdata[0] = cfg.has_cleanup_mux;
      default: ;
    endcase
  end

endmodule

[hdl/ltc_event_core.sv]
// ---------------------------------------------------------------------------
// ltc_event_core
// Link, equalization, rate and slot state with the per-event update logic.
// ---------------------------------------------------------------------------
module ltc_event_core (
  input  logic                  clk,
  input  logic                  rst,
  input  ltc_pkg::ltc_cfg_t     cfg,
  input  ltc_pkg::ltc_item_t    item,
  input  logic                  fire,
  output ltc_pkg::ltc_result_t  result
);
  import ltc_pkg::*;

  // State registers
  logic [3:0]  ltssm_state, ltssm_state_next;
  logic        link_up, link_up_next;
  logic        training, training_next;
  logic [2:0]  eq_phase, eq_phase_next;
  logic        eq_flag, eq_flag_next;
  logic [2:0]  preset, preset_next;
  logic [2:0]  rate, rate_next;
  logic        sw_pending, sw_pending_next;
  logic [2:0]  sw_target, sw_target_next;
  logic [3:0]  slot, slot_next;
  logic [15:0] removal_count, removal_count_next;
  logic [15:0] insertion_count, insertion_count_next;

  logic [1:0]  cleanup;
  logic [1:0]  swev;
  logic        reached;
  logic        lvl;
  logic [2:0]  sat_val;
  logic [1:0]  slot_idx;
  logic        card_seen;

  assign lvl      = (item.value != 3'd0);
  assign sat_val  = (item.value > RATE_MAX) ? RATE_MAX : item.value;
  assign slot_idx = item.mode[1:0] + 2'd2;  // MRL, PWRGOOD, REFCLK -> bits 1..3
  assign card_seen = slot[SLOT_PRESENT];

  // Next-state logic for one event
  always_comb begin
    ltssm_state_next     = ltssm_state;
    link_up_next         = link_up;
    training_next        = training;
    eq_phase_next        = eq_phase;
    eq_flag_next         = eq_flag;
    preset_next          = preset;
    rate_next            = rate;
    sw_pending_next      = sw_pending;
    sw_target_next       = sw_target;
    slot_next            = slot;
    removal_count_next   = removal_count;
    insertion_count_next = insertion_count;
    cleanup              = CLEANUP_NONE;
    swev                 = SWEV_NONE;
    reached              = 1'b0;

    unique case (item.mode)
      MODE_TICK, MODE_TRAIN_STEP: begin
        // One training step
        if (training) begin
          unique case (ltssm_state)
            ST_DETECT:  ltssm_state_next = ST_POLLING;
            ST_POLLING: ltssm_state_next = ST_CONFIG;
            ST_CONFIG: begin
              ltssm_state_next = ST_L0;
              link_up_next     = 1'b1;
              training_next    = 1'b0;
            end
            default: ;
          endcase
        end
        if (item.mode == MODE_TRAIN_STEP) begin
          reached = (ltssm_state_next == ST_L0);
        end else if (sw_pending && (item.switch_ready || !cfg.has_link_layer)) begin
          sw_pending_next  = 1'b0;
          rate_next        = sw_target;
          ltssm_state_next = ST_L0;
          link_up_next     = 1'b1;
          swev             = SWEV_DONE;
        end
      end
      MODE_TRAIN: begin
        ltssm_state_next = ST_DETECT;
        link_up_next     = 1'b0;
        training_next    = 1'b1;
      end
      MODE_LINK_SET: begin
        link_up_next = lvl;
        if (!lvl) begin
          ltssm_state_next = ST_DETECT;
          eq_flag_next     = 1'b0;
          eq_phase_next    = EQ_IDLE;
          training_next    = 1'b0;
        end
      end
      MODE_RATE_SET: rate_next = sat_val;
      MODE_RATE_SW: begin
        if (sat_val != rate) begin
          link_up_next  = 1'b0;
          training_next = 1'b0;
          if (cfg.has_link_layer) begin
            sw_pending_next  = 1'b1;
            sw_target_next   = sat_val;
            ltssm_state_next = ST_RECOVERY;
            swev             = SWEV_START;
          end else begin
            // No link layer: switch completes at once
            sw_pending_next  = 1'b0;
            sw_target_next   = sat_val;
            rate_next        = sat_val;
            ltssm_state_next = ST_L0;
            link_up_next     = 1'b1;
            swev             = SWEV_DONE;
          end
        end
      end
      MODE_L0S: begin
        ltssm_state_next = ST_L0S;
        link_up_next     = 1'b0;
      end
      MODE_L1: begin
        ltssm_state_next = ST_L1;
        link_up_next     = 1'b0;
      end
      MODE_L2: begin
        ltssm_state_next = ST_L2;
        link_up_next     = 1'b0;
      end
      MODE_LP_EXIT: begin
        if (ltssm_state == ST_L0S || ltssm_state == ST_L1) begin
          ltssm_state_next = ST_L0;
          link_up_next     = 1'b1;
        end
      end
      MODE_DISABLE: begin
        ltssm_state_next = ST_DISABLED;
        link_up_next     = 1'b0;
      end
      MODE_LOOPBACK: begin
        ltssm_state_next = ST_LOOPBACK;
        link_up_next     = 1'b0;
      end
      MODE_HOTRESET: begin
        ltssm_state_next = ST_HOTRESET;
        link_up_next     = 1'b0;
      end
      MODE_EQ_START: begin
        eq_flag_next  = 1'b1;
        eq_phase_next = EQ_TS1;
        preset_next   = 3'd0;
      end
      MODE_PRESET: begin
        if (item.value <= PRESET_MAX) preset_next = item.value;
      end
      MODE_TS1: begin
        if (eq_phase == EQ_IDLE) eq_phase_next = EQ_TS1;
        eq_flag_next = 1'b1;
      end
      MODE_TS2: begin
        if (eq_phase != EQ_DONE) eq_phase_next = EQ_TS2;
      end
      MODE_EQ_STEP: begin
        if (eq_phase >= EQ_TS1 && eq_phase <= EQ_PH2) begin
          eq_phase_next = eq_phase + 3'd1;
        end else if (eq_phase == EQ_PH3) begin
          eq_phase_next = EQ_DONE;
          eq_flag_next  = 1'b0;
        end
        reached = (eq_phase_next == EQ_DONE);
      end
      MODE_PRSNT: begin
        slot_next[SLOT_PRESENT] = lvl;
        if (card_seen && !lvl) begin
          // Surprise removal
          removal_count_next = removal_count + 16'd1;
          if (cfg.has_cleanup_mux)     cleanup = CLEANUP_MUX;
          else if (cfg.has_link_layer) cleanup = CLEANUP_LINK;
          ltssm_state_next = ST_DETECT;
          link_up_next     = 1'b0;
          eq_flag_next     = 1'b0;
          eq_phase_next    = EQ_IDLE;
          training_next    = 1'b0;
        end else if (!card_seen && lvl) begin
          insertion_count_next = insertion_count + 16'd1;
        end
      end
      MODE_MRL, MODE_PWRGOOD, MODE_REFCLK: slot_next[slot_idx] = lvl;
      MODE_PERST: begin
        if (lvl) begin
          if (ltssm_state == ST_RECOVERY || ltssm_state == ST_HOTRESET) begin
            ltssm_state_next = ST_HOTRESET;
            link_up_next     = 1'b0;
          end else begin
            ltssm_state_next = ST_DETECT;
            link_up_next     = 1'b0;
            eq_flag_next     = 1'b0;
            eq_phase_next    = EQ_IDLE;
            training_next    = 1'b0;
          end
        end else if (slot == SLOT_ALL) begin
          ltssm_state_next = ST_DETECT;
          link_up_next     = 1'b0;
          training_next    = 1'b1;
        end
      end
      default: ;  // unused event codes change nothing
    endcase
  end

  // Result for the current event
  always_comb begin
    result.link_state          = ltssm_state_next;
    result.link_is_up          = link_up_next;
    result.eq_phase_out        = eq_phase_next;
    result.preset_out          = preset_next;
    result.rate_out            = rate_next;
    result.training_active     = training_next;
    result.eq_active           = eq_flag_next;
    result.removal_count_out   = removal_count_next;
    result.insertion_count_out = insertion_count_next;
    result.cleanup_request     = cleanup;
    result.rate_switch_event   = swev;
    result.step_reached        = reached;
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      ltssm_state     <= ST_DETECT;
      link_up         <= 1'b0;
      training        <= 1'b0;
      eq_phase        <= EQ_IDLE;
      eq_flag         <= 1'b0;
      preset          <= 3'd0;
      rate            <= 3'd0;
      sw_pending      <= 1'b0;
      sw_target       <= 3'd0;
      slot            <= 4'd0;
      removal_count   <= 16'd0;
      insertion_count <= 16'd0;
    end else if (fire) begin
      ltssm_state     <= ltssm_state_next;
      link_up         <= link_up_next;
      training        <= training_next;
      eq_phase        <= eq_phase_next;
      eq_flag         <= eq_flag_next;
      preset          <= preset_next;
      rate            <= rate_next;
      sw_pending      <= sw_pending_next;
      sw_target       <= sw_target_next;
      slot            <= slot_next;
      removal_count   <= removal_count_next;
      insertion_count <= insertion_count_next;
    end
  end

endmodule

[tb/sv/pcie_link_training_controller_tb.sv]
// ---------------------------------------------------------------------------
// pcie_link_training_controller_tb
// Self-checking bench for the simplified link-training controller. Events go
// in on the slave stream, one status item per event comes back on the master
// stream and is compared field by field against an in-bench model of the
// link state, equalization, rate switch, slot signals and counters. A short
// directed table opens the run; random bursts follow under four settings of
// the two APB config registers, random idling on both sides but in the second.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcie_link_training_controller_tb;
  import ltc_pkg::*;

  localparam logic [4:0] MODE_UNUSED = 5'd31;
  localparam int         N_DIR       = 30;
  localparam int         N_PHASE     = 4;
  localparam int         PHASE_ITEMS = 450;
  localparam int         LIMIT       = 200000;

  typedef struct packed {
    logic [4:0]  mode;
    logic [2:0]  arg;
    logic        ready;
    logic        pinned;   // want is typed in, not taken from the model
    ltc_result_t want;
  } step_row_t;

  // DUT signals; the inputs are known from time zero
  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;  // value[2:0], switch_ready[3], zero [7:4]
  logic [S_TUSER_W-1:0]  s_tuser  = '0;  // mode[4:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // link_state[3:0], link_is_up[4], eq_phase_out[7:5], preset_out[10:8],
  // rate_out[13:11], training_active[14], eq_active[15],
  // removal_count_out[31:16], insertion_count_out[47:32],
  // cleanup_request[49:48], rate_switch_event[51:50], step_reached[52], zero [55:53]
  logic [M_TDATA_W-1:0]  m_tdata;

  // Model state and config
  logic [3:0]  lk_state;
  logic        lk_up;
  logic        train_on;
  logic [2:0]  eq_ph;
  logic        eq_on;
  logic [2:0]  preset;
  logic [2:0]  rate;
  logic        sw_pend;
  logic [2:0]  sw_to;
  logic [3:0]  slot;
  logic [15:0] n_removed;
  logic [15:0] n_inserted;
  logic        cfg_ll;
  logic        cfg_mux;

  ltc_result_t status_due[$];
  int          fails    = 0;
  int          cycles   = 0;
  int          n_sent   = 0;
  logic        steady   = 1'b0;  // no idling on either side while set
  logic        next_pin = 1'b0;
  ltc_result_t next_want = '0;
  logic        pin_now  = 1'b0;
  ltc_result_t pin_want = '0;

  step_row_t opening [N_DIR] = '{
    // reset values, then an unknown code that changes nothing
    '{MODE_TICK,       3'd0, 1'b0, 1'b1, '0},
    '{MODE_UNUSED,     3'd7, 1'b1, 1'b1, '0},
    // out-of-range rate saturates; switch to the current rate is a no-op
    '{MODE_RATE_SET,   3'd7, 1'b0, 1'b1, '{rate_out: RATE_MAX, default: '0}},
    '{MODE_RATE_SW,    3'd5, 1'b0, 1'b1, '{rate_out: RATE_MAX, default: '0}},
    '{MODE_RATE_SW,    3'd1, 1'b0, 1'b1,
      '{link_state: ST_RECOVERY, rate_out: RATE_MAX, rate_switch_event: SWEV_START,
        default: '0}},
    // switch waits for the link layer, then completes
    '{MODE_TICK,       3'd0, 1'b0, 1'b0, '0},
    '{MODE_TICK,       3'd0, 1'b1, 1'b1,
      '{link_state: ST_L0, link_is_up: 1'b1, rate_out: 3'd1,
        rate_switch_event: SWEV_DONE, default: '0}},
    // equalization walk to Complete
    '{MODE_PRESET,     3'd7, 1'b0, 1'b0, '0},
    '{MODE_EQ_START,   3'd0, 1'b0, 1'b0, '0},
    '{MODE_TS1,        3'd0, 1'b0, 1'b0, '0},
    '{MODE_TS2,        3'd0, 1'b0, 1'b0, '0},
    '{MODE_EQ_STEP,    3'd0, 1'b0, 1'b0, '0},
    '{MODE_EQ_STEP,    3'd0, 1'b0, 1'b0, '0},
    '{MODE_EQ_STEP,    3'd0, 1'b0, 1'b0, '0},
    // L2 is not left by the low-power exit, L1 is
    '{MODE_L2,         3'd0, 1'b0, 1'b0, '0},
    '{MODE_LP_EXIT,    3'd0, 1'b0, 1'b0, '0},
    '{MODE_L1,         3'd0, 1'b0, 1'b0, '0},
    '{MODE_LP_EXIT,    3'd0, 1'b0, 1'b0, '0},
    // PERST in HotReset stays in HotReset
    '{MODE_HOTRESET,   3'd0, 1'b0, 1'b0, '0},
    '{MODE_PERST,      3'd1, 1'b0, 1'b0, '0},
    // all slot signals up, PERST released: training starts
    '{MODE_PRSNT,      3'd7, 1'b0, 1'b0, '0},
    '{MODE_MRL,        3'd1, 1'b0, 1'b0, '0},
    '{MODE_PWRGOOD,    3'd4, 1'b0, 1'b0, '0},
    '{MODE_REFCLK,     3'd2, 1'b0, 1'b0, '0},
    '{MODE_PERST,      3'd0, 1'b0, 1'b0, '0},
    '{MODE_TRAIN_STEP, 3'd0, 1'b0, 1'b0, '0},
    '{MODE_TICK,       3'd0, 1'b0, 1'b0, '0},
    '{MODE_TRAIN_STEP, 3'd0, 1'b0, 1'b0, '0},
    // link down, then surprise removal with link-layer cleanup
    '{MODE_LINK_SET,   3'd0, 1'b0, 1'b0, '0},
    '{MODE_PRSNT,      3'd0, 1'b0, 1'b0, '0}
  };

  pcie_link_training_controller i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("pcie_link_training_controller_tb failed");
      $finish;
    end
  end

  // ---- link model ----

  function automatic void drop_link();
    lk_state = ST_DETECT;
    lk_up    = 1'b0;
    eq_on    = 1'b0;
    eq_ph    = EQ_IDLE;
    train_on = 1'b0;
  endfunction

  function automatic void start_training();
    lk_state = ST_DETECT;
    lk_up    = 1'b0;
    train_on = 1'b1;
  endfunction

  function automatic void train_advance();
    if (train_on) begin
      case (lk_state)
        ST_DETECT: lk_state = ST_POLLING;
        ST_POLLING: lk_state = ST_CONFIG;
        ST_CONFIG: begin
          lk_state = ST_L0;
          lk_up    = 1'b1;
          train_on = 1'b0;
        end
        default: ;
      endcase
    end
  endfunction

  function automatic void complete_switch();
    sw_pend  = 1'b0;
    rate     = sw_to;
    lk_state = ST_L0;
    lk_up    = 1'b1;
  endfunction

  // Apply one event to the model and return the status it should produce
  function automatic ltc_result_t advance_link(input logic [4:0] ev, input logic [2:0] arg,
                                               input logic rdy);
    ltc_result_t r;
    logic        lvl;
    logic        was;
    logic [2:0]  to;
    r   = '0;
    lvl = (arg != 3'd0);
    to  = (arg > RATE_MAX) ? RATE_MAX : arg;
    case (ev)
      MODE_TICK: begin
        train_advance();
        if (sw_pend && (rdy || !cfg_ll)) begin
          complete_switch();
          r.rate_switch_event = SWEV_DONE;
        end
      end
      MODE_TRAIN: start_training();
      MODE_LINK_SET: begin
        lk_up = lvl;
        if (!lvl) begin
          lk_state = ST_DETECT;
          eq_on    = 1'b0;
          eq_ph    = EQ_IDLE;
          train_on = 1'b0;
        end
      end
      MODE_RATE_SET: rate = to;
      MODE_RATE_SW: begin
        if (to != rate) begin
          sw_pend  = 1'b1;
          sw_to    = to;
          lk_state = ST_RECOVERY;
          lk_up    = 1'b0;
          train_on = 1'b0;
          if (cfg_ll) begin
            r.rate_switch_event = SWEV_START;
          end else begin
            complete_switch();
            r.rate_switch_event = SWEV_DONE;
          end
        end
      end
      MODE_L0S, MODE_L1, MODE_L2: begin
        lk_state = ST_L0S + 4'(ev - MODE_L0S);
        lk_up    = 1'b0;
      end
      MODE_LP_EXIT: begin
        if (lk_state == ST_L0S || lk_state == ST_L1) begin
          lk_state = ST_L0;
          lk_up    = 1'b1;
        end
      end
      MODE_DISABLE: begin
        lk_state = ST_DISABLED;
        lk_up    = 1'b0;
      end
      MODE_LOOPBACK: begin
        lk_state = ST_LOOPBACK;
        lk_up    = 1'b0;
      end
      MODE_HOTRESET: begin
        lk_state = ST_HOTRESET;
        lk_up    = 1'b0;
      end
      MODE_EQ_START: begin
        eq_on  = 1'b1;
        eq_ph  = EQ_TS1;
        preset = 3'd0;
      end
      MODE_PRESET: preset = arg;  // every 3-bit value is a legal preset
      MODE_TS1: begin
        if (eq_ph == EQ_IDLE) eq_ph = EQ_TS1;
        eq_on = 1'b1;
      end
      MODE_TS2: begin
        if (eq_ph != EQ_DONE) eq_ph = EQ_TS2;
      end
      MODE_EQ_STEP: begin
        if (eq_ph >= EQ_TS1 && eq_ph <= EQ_PH2) begin
          eq_ph = eq_ph + 3'd1;
        end else if (eq_ph == EQ_PH3) begin
          eq_ph = EQ_DONE;
          eq_on = 1'b0;
        end
        r.step_reached = (eq_ph == EQ_DONE);
      end
      MODE_TRAIN_STEP: begin
        train_advance();
        r.step_reached = (lk_state == ST_L0);
      end
      MODE_PRSNT: begin
        was = slot[SLOT_PRESENT];
        slot[SLOT_PRESENT] = lvl;
        if (was && !lvl) begin
          n_removed = n_removed + 16'd1;
          if (cfg_mux) r.cleanup_request = CLEANUP_MUX;
          else if (cfg_ll) r.cleanup_request = CLEANUP_LINK;
          drop_link();
        end else if (!was && lvl) begin
          n_inserted = n_inserted + 16'd1;
        end
      end
      MODE_MRL, MODE_PWRGOOD, MODE_REFCLK: slot[2'(ev - MODE_PRSNT)] = lvl;
      MODE_PERST: begin
        if (lvl) begin
          if (lk_state == ST_RECOVERY || lk_state == ST_HOTRESET) begin
            lk_state = ST_HOTRESET;
            lk_up    = 1'b0;
          end else begin
            drop_link();
          end
        end else if (slot == SLOT_ALL) begin
          start_training();
        end
      end
      default: ;
    endcase
    r.link_state          = lk_state;
    r.link_is_up          = lk_up;
    r.eq_phase_out        = eq_ph;
    r.preset_out          = preset;
    r.rate_out            = rate;
    r.training_active     = train_on;
    r.eq_active           = eq_on;
    r.removal_count_out   = n_removed;
    r.insertion_count_out = n_inserted;
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // ---- monitors ----

  // Accepted event: run the model and queue the status it predicts
  always @(posedge clk) begin
    ltc_result_t p;
    if (!rst && s_tvalid && s_tready) begin
      p = advance_link(s_tuser, s_tdata[2:0], s_tdata[3]);
      status_due.push_back(pin_now ? pin_want : p);
    end
  end

  // Accepted status item: compare with the oldest prediction
  always @(posedge clk) begin
    ltc_result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (status_due.size() == 0) begin
        $error("status item with nothing expected: %h", m_tdata);
        fails++;
      end else begin
        w = status_due.pop_front();
        check_field("link_state",          w.link_state,          m_tdata[3:0]);
        check_field("link_is_up",          w.link_is_up,          m_tdata[4]);
        check_field("eq_phase_out",        w.eq_phase_out,        m_tdata[7:5]);
        check_field("preset_out",          w.preset_out,          m_tdata[10:8]);
        check_field("rate_out",            w.rate_out,            m_tdata[13:11]);
        check_field("training_active",     w.training_active,     m_tdata[14]);
        check_field("eq_active",           w.eq_active,           m_tdata[15]);
        check_field("removal_count_out",   w.removal_count_out,   m_tdata[31:16]);
        check_field("insertion_count_out", w.insertion_count_out, m_tdata[47:32]);
        check_field("cleanup_request",     w.cleanup_request,     m_tdata[49:48]);
        check_field("rate_switch_event",   w.rate_switch_event,   m_tdata[51:50]);
        check_field("step_reached",        w.step_reached,        m_tdata[52]);
      end
    end
  end

  // Receiver stalls about a quarter of the cycles while steady is clear
  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(0, 99) >= 25);
  end

  // ---- drivers (entered and left at a falling edge) ----

  task automatic drive_event(input logic [4:0] ev, input logic [2:0] arg, input logic rdy);
    if (!steady && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev;
    s_tdata  <= {4'b0000, rdy, arg};
    pin_now  <= next_pin;
    pin_want <= next_want;
    next_pin = 1'b0;
    do @(posedge clk); while (!s_tready);
    if (ev <= MODE_PERST) n_sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every status item is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (status_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write a config register, then read it back
  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {31'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_LINK_LAYER) cfg_ll = val;
    else cfg_mux = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("prdata", val, prdata[0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [2:0] level_arg();
    return ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
  endfunction

  // One random burst, mostly well-formed event sequences
  task automatic play_burst();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin  // training walk
        drive_event(MODE_TRAIN, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 5)) begin
          drive_event($urandom_range(0, 1) ? MODE_TICK : MODE_TRAIN_STEP,
                      3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
      end
      2: begin  // equalization
        drive_event($urandom_range(0, 2) != 0 ? MODE_EQ_START : MODE_TS1,
                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) drive_event(MODE_PRESET, 3'($urandom_range(0, 7)), 1'b0);
        if ($urandom_range(0, 1)) drive_event(MODE_TS2, 3'($urandom_range(0, 7)), 1'b0);
        repeat ($urandom_range(2, 5)) begin
          drive_event($urandom_range(0, 4) != 0 ? MODE_EQ_STEP : MODE_PRESET,
                      3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
      end
      3: begin  // rate change
        if ($urandom_range(0, 3) == 0) drive_event(MODE_RATE_SET, 3'($urandom_range(0, 7)), 1'b0);
        drive_event(MODE_RATE_SW, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 4)) begin
          drive_event(MODE_TICK, 3'($urandom_range(0, 7)), ($urandom_range(0, 2) == 0));
        end
      end
      4: begin  // slot bring-up and PERST
        drive_event(MODE_PRSNT, level_arg(), 1'b0);
        drive_event(MODE_MRL, level_arg(), 1'b0);
        drive_event(MODE_PWRGOOD, level_arg(), 1'b0);
        drive_event(MODE_REFCLK, level_arg(), 1'b0);
        drive_event(MODE_PERST, 3'($urandom_range(1, 7)), 1'b0);
        drive_event(MODE_PERST, 3'd0, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 4)) drive_event(MODE_TRAIN_STEP, 3'd0, 1'b0);
      end
      5: begin  // removal and insertion
        drive_event(MODE_PRSNT, 3'd0, 1'($urandom_range(0, 1)));
        drive_event(MODE_PRSNT, 3'($urandom_range(1, 7)), 1'($urandom_range(0, 1)));
      end
      6: begin  // low power entry and exit
        drive_event(5'($urandom_range(MODE_L0S, MODE_L2)), 3'($urandom_range(0, 7)), 1'b0);
        if ($urandom_range(0, 2) == 0) drive_event(MODE_TICK, 3'd0, 1'($urandom_range(0, 1)));
        drive_event($urandom_range(0, 3) != 0 ? MODE_LP_EXIT : MODE_LINK_SET,
                    level_arg(), 1'($urandom_range(0, 1)));
      end
      7: begin  // disable, loopback, hot reset and their way out
        drive_event(5'($urandom_range(MODE_DISABLE, MODE_HOTRESET)),
                    3'($urandom_range(0, 7)), 1'b0);
        drive_event($urandom_range(0, 1) ? MODE_PERST : MODE_LINK_SET, level_arg(),
                    1'($urandom_range(0, 1)));
      end
      default: begin  // noise, unknown codes included
        repeat ($urandom_range(1, 6)) begin
          drive_event(5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
        end
      end
    endcase
  endtask

  // ---- test sequence ----

  initial begin
    logic ph_ll  [N_PHASE] = '{1'b0, 1'b1, 1'b0, 1'b1};
    logic ph_mux [N_PHASE] = '{1'b0, 1'b1, 1'b1, 1'b0};
    int   goal;
    lk_state   = ST_DETECT;
    lk_up      = 1'b0;
    train_on   = 1'b0;
    eq_ph      = EQ_IDLE;
    eq_on      = 1'b0;
    preset     = 3'd0;
    rate       = 3'd0;
    sw_pend    = 1'b0;
    sw_to      = 3'd0;
    slot       = 4'd0;
    n_removed  = 16'd0;
    n_inserted = 16'd0;
    cfg_ll     = 1'b1;
    cfg_mux    = 1'b0;

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed table under the reset config
    for (int i = 0; i < N_DIR; i++) begin
      next_pin  = opening[i].pinned;
      next_want = opening[i].want;
      drive_event(opening[i].mode, opening[i].arg, opening[i].ready);
    end

    // random bursts under each config setting
    for (int ph = 0; ph < N_PHASE; ph++) begin
      drain();
      write_reg(REG_LINK_LAYER, ph_ll[ph]);
      write_reg(REG_CLEANUP_MUX, ph_mux[ph]);
      steady = (ph == 1);
      goal   = n_sent + PHASE_ITEMS;
      while (n_sent < goal) begin
        play_burst();
        // in the third setting, hold off mid-phase until the pipe is empty
        if (ph == 2 && n_sent >= goal - PHASE_ITEMS / 2 && n_sent < goal - PHASE_ITEMS / 2 + 8)
          drain();
      end
      steady = 1'b0;
    end

    drain();
    if (fails == 0) begin
      $display("pcie_link_training_controller_tb passed");
    end else begin
      $display("pcie_link_training_controller_tb failed");
    end
    $finish;
  end

endmodule
